[src/mecf_pkg.sv]
// shared types and constants for the minimum edge cut block
`timescale 1ns / 1ps

package mecf_pkg;

	// widths fixed by the word fields
	localparam int NODE_W  = 5;
	localparam int CNT_W   = 6;
	localparam int CFG_W   = 6;
	localparam int CADDR_W = 2;
	localparam int LAB_W   = 2;
	localparam int CAP_W   = 2;

	// largest node count that the node fields can address
	localparam int NODE_LIMIT = 32;

	// operation codes of an input word
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_RUN   = 1'b1;

	// register indexes
	localparam logic [CADDR_W-1:0] REG_NODE_COUNT = 2'd0;
	localparam logic [CADDR_W-1:0] REG_SOURCE     = 2'd1;
	localparam logic [CADDR_W-1:0] REG_SINK       = 2'd2;

	// register reset values
	localparam logic [CNT_W-1:0]  NODE_COUNT_RST = 6'd32;
	localparam logic [NODE_W-1:0] SOURCE_RST     = 5'd0;
	localparam logic [NODE_W-1:0] SINK_RST       = 5'd31;

	// path width labels: capacities are 0..2, so the source mark sits above them
	localparam logic [LAB_W-1:0] LAB_ZERO = 2'd0;
	localparam logic [LAB_W-1:0] LAB_INF  = 2'd3;

	// result status codes
	localparam logic ST_OK       = 1'b0;
	localparam logic ST_SAME_END = 1'b1;

	// command to the flow engine
	typedef struct packed {
		logic              start;
		logic [CNT_W-1:0]  n;
		logic [NODE_W-1:0] src;
		logic [NODE_W-1:0] snk;
	} flow_cmd_t;

	// status from the flow engine
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [CNT_W-1:0] total;
	} flow_stat_t;

endpackage

[src/mecf_flow.sv]
// widest-path max flow engine with its residual capacity memory
`timescale 1ns / 1ps

module mecf_flow #(
	parameter int NODES = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mecf_pkg::flow_cmd_t      cmd,
	input  logic                     ld_we,
	input  logic [$clog2(NODES)-1:0] ld_addr,
	input  logic [NODES-1:0]         ld_row,
	output mecf_pkg::flow_stat_t     stat
);
	import mecf_pkg::*;

	localparam int IW = $clog2(NODES);
	localparam int RW = CAP_W * NODES;

	typedef enum logic [11:0] {
		F_IDLE  = 12'b000000000001,
		F_INIT  = 12'b000000000010,
		F_SCAN  = 12'b000000000100,
		F_RREQ  = 12'b000000001000,
		F_RELAX = 12'b000000010000,
		F_AUG   = 12'b000000100000,
		F_ACHK  = 12'b000001000000,
		F_ARA   = 12'b000010000000,
		F_AWA   = 12'b000100000000,
		F_ARB   = 12'b001000000000,
		F_AWB   = 12'b010000000000,
		F_DONE  = 12'b100000000000
	} fstate_t;

	fstate_t state_q, state_d;

	logic [RW-1:0]    res_mem [NODES];
	logic [RW-1:0]    rd_q;
	logic [LAB_W-1:0] lab_q [NODES];
	logic [NODES-1:0] vis_q;
	logic [IW-1:0]    par_q [NODES];

	logic [CNT_W-1:0] n_q, guard_q, total_q;
	logic [IW-1:0]    s_q, t_q, i_q, pick_q, cur_q, apar_q;
	logic [LAB_W-1:0] plab_q;
	logic [CAP_W-1:0] amt_q;
	logic             found_q;

	logic             cand, found_n, scan_end, out_range;
	logic [IW-1:0]    pick_n;
	logic [LAB_W-1:0] plab_n;

	logic             mem_we;
	logic [IW-1:0]    mem_waddr, mem_raddr;
	logic [RW-1:0]    mem_wdata;

	// one node of the widest label search per cycle in the scan state
	always_comb begin
		cand     = !vis_q[i_q] && (lab_q[i_q] != LAB_ZERO) &&
		           (!found_q || (lab_q[i_q] > plab_q));
		found_n  = found_q | cand;
		pick_n   = cand ? i_q : pick_q;
		plab_n   = cand ? lab_q[i_q] : plab_q;
		scan_end = ((CNT_W'(i_q) + CNT_W'(1)) == n_q);
		out_range = ({1'b0, cmd.src} >= cmd.n) || ({1'b0, cmd.snk} >= cmd.n);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (cmd.start) state_d = out_range ? F_DONE : F_INIT;
			end
			F_INIT:  state_d = F_SCAN;
			F_SCAN: begin
				if (scan_end) begin
					if (!found_n)            state_d = F_DONE;
					else if (pick_n == t_q)  state_d = F_AUG;
					else                     state_d = F_RREQ;
				end
			end
			F_RREQ:  state_d = F_RELAX;
			F_RELAX: state_d = F_SCAN;
			F_AUG:   state_d = F_ACHK;
			F_ACHK:  state_d = ((cur_q == s_q) || (guard_q >= n_q)) ? F_INIT : F_ARA;
			F_ARA:   state_d = F_AWA;
			F_AWA:   state_d = F_ARB;
			F_ARB:   state_d = F_AWB;
			F_AWB:   state_d = F_ACHK;
			F_DONE:  state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= F_IDLE;
		else         state_q <= state_d;
	end

	// working registers of the search and the augmentation walk
	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (cmd.start) begin
					n_q     <= cmd.n;
					s_q     <= cmd.src[IW-1:0];
					t_q     <= cmd.snk[IW-1:0];
					total_q <= '0;
				end
			end
			F_INIT: begin
				for (int j = 0; j < NODES; j++) begin
					vis_q[j] <= 1'b0;
					lab_q[j] <= (IW'(j) == s_q) ? LAB_INF : LAB_ZERO;
				end
				i_q        <= '0;
				found_q    <= 1'b0;
			end
			F_SCAN: begin
				found_q <= found_n;
				pick_q  <= pick_n;
				plab_q  <= plab_n;
				i_q     <= i_q + IW'(1);
				if (scan_end && found_n && (pick_n != t_q)) vis_q[pick_n] <= 1'b1;
			end
			F_RELAX: begin
				for (int j = 0; j < NODES; j++) begin
					if ((rd_q[CAP_W*j +: CAP_W] > lab_q[j]) && (plab_q > lab_q[j])) begin
						lab_q[j] <= (rd_q[CAP_W*j +: CAP_W] < plab_q) ?
						            rd_q[CAP_W*j +: CAP_W] : plab_q;
						par_q[j] <= pick_q;
					end
				end
				i_q     <= '0;
				found_q <= 1'b0;
			end
			F_AUG: begin
				amt_q   <= lab_q[t_q];
				total_q <= total_q + CNT_W'(lab_q[t_q]);
				cur_q   <= t_q;
				guard_q <= '0;
			end
			F_ACHK: apar_q <= par_q[cur_q];
			F_AWB: begin
				cur_q   <= apar_q;
				guard_q <= guard_q + CNT_W'(1);
			end
			F_RREQ, F_ARA, F_AWA, F_ARB, F_DONE: ;
			default: ;
		endcase
	end

	// memory port selection: row loads, then read-modify-write of the path
	always_comb begin
		mem_raddr = pick_q;
		mem_we    = ld_we;
		mem_waddr = ld_addr;
		mem_wdata = '0;
		for (int j = 0; j < NODES; j++) mem_wdata[CAP_W*j +: CAP_W] = {1'b0, ld_row[j]};
		unique case (state_q)
			F_ARA: mem_raddr = apar_q;
			F_ARB: mem_raddr = cur_q;
			F_AWA: begin
				mem_we    = 1'b1;
				mem_waddr = apar_q;
				mem_wdata = rd_q;
				mem_wdata[{cur_q, 1'b0} +: CAP_W] = rd_q[{cur_q, 1'b0} +: CAP_W] - amt_q;
			end
			F_AWB: begin
				mem_we    = 1'b1;
				mem_waddr = cur_q;
				mem_wdata = rd_q;
				mem_wdata[{apar_q, 1'b0} +: CAP_W] = rd_q[{apar_q, 1'b0} +: CAP_W] + amt_q;
			end
			F_IDLE, F_INIT, F_SCAN, F_RREQ, F_RELAX, F_AUG, F_ACHK, F_DONE: ;
			default: ;
		endcase
	end

	// residual capacity rows
	always_ff @(posedge clk) begin
		if (mem_we) res_mem[mem_waddr] <= mem_wdata;
		rd_q <= res_mem[mem_raddr];
	end

	assign stat.busy  = (state_q != F_IDLE);
	assign stat.done  = (state_q == F_DONE);
	assign stat.total = total_q;

endmodule

[src/min_edge_cut_by_max_flow.sv]
// top level: adjacency matrix, edge trial sequencer and result words
// Minimum source-sink edge cut of a small directed graph.
// Input channel (in_valid/in_ready): a word with op write stores one
// adjacency entry and is taken one per cycle. A word with op run finds the
// cut: the block drops in_ready until every result word of the run has gone.
// A run computes a max flow, then tries each present edge in row-major
// order while flow remains; each trial reloads the residual rows and
// reruns the flow engine, whose node search scans one node per cycle.
// Output channel (out_valid/out_ready): one word per cut edge with last on
// the final one, or a single word for an empty cut or source equal to sink.
// A stalled receiver simply holds the current result word; nothing is lost.
// Configuration registers (cfg_we/cfg_addr/cfg_data) must be written only
// while idle; the block does not enforce it. Reset clears the adjacency
// matrix and sets 32 nodes, source 0, sink 31; no clearing pass is needed.
`timescale 1ns / 1ps

module min_edge_cut_by_max_flow #(
	parameter int MAX_NODES = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mecf_pkg::CADDR_W-1:0]    cfg_addr,
	input  logic [mecf_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            op,
	input  logic [mecf_pkg::NODE_W-1:0]     row_node,
	input  logic [mecf_pkg::NODE_W-1:0]     col_node,
	input  logic                            edge_present,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            status,
	output logic                            edge_valid,
	output logic [mecf_pkg::NODE_W-1:0]     cut_from,
	output logic [mecf_pkg::NODE_W-1:0]     cut_to,
	output logic [mecf_pkg::NODE_W-1:0]     cut_size,
	output logic                            last
);
	import mecf_pkg::*;

	localparam int NODES = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;
	localparam int IW    = $clog2(NODES);

	typedef enum logic [6:0] {
		T_IDLE   = 7'b0000001,
		T_LOAD   = 7'b0000010,
		T_FSTART = 7'b0000100,
		T_FWAIT  = 7'b0001000,
		T_SCAN   = 7'b0010000,
		T_EMIT   = 7'b0100000,
		T_OUT    = 7'b1000000
	} tstate_t;

	tstate_t state_q, state_d;

	logic [CNT_W-1:0]  node_count_q;
	logic [NODE_W-1:0] source_q, sink_q;

	logic [NODES-1:0] adj_q [NODES];
	logic [NODES-1:0] red_q [NODES];
	logic [IW-1:0]    from_q [NODES];
	logic [IW-1:0]    to_q [NODES];

	logic [CNT_W-1:0] n_q, k_q, flow_q, count_q, idx_q;
	logic [IW-1:0]    l_q, r_q;
	logic             base_q, err_q;

	logic [CNT_W-1:0] neff;
	logic             in_acc, run_acc, out_acc, l_end, cur_edge, trial_cut;
	logic [NODES-1:0] colmask, ld_row;

	flow_cmd_t  fcmd;
	flow_stat_t fstat;

	assign in_ready  = (state_q == T_IDLE);
	assign out_valid = (state_q == T_OUT);
	assign in_acc    = in_valid && in_ready;
	assign run_acc   = in_acc && (op == OP_RUN);
	assign out_acc   = out_valid && out_ready;

	// node count clipped to the stored matrix size
	assign neff = (node_count_q > CNT_W'(NODES)) ? CNT_W'(NODES) : node_count_q;

	// edge under consideration and trial outcome
	assign l_end     = ((CNT_W'(l_q) + CNT_W'(1)) == n_q);
	assign cur_edge  = red_q[k_q[IW-1:0]][l_q];
	assign trial_cut = (fstat.total < flow_q);

	// residual row load: columns in use, trial edge taken out
	always_comb begin
		for (int j = 0; j < NODES; j++) colmask[j] = (32'(j) < 32'(n_q));
		ld_row = red_q[r_q] & colmask;
		if (!base_q && (r_q == k_q[IW-1:0])) ld_row[l_q] = 1'b0;
	end

	assign fcmd.start = (state_q == T_FSTART);
	assign fcmd.n     = n_q;
	assign fcmd.src   = source_q;
	assign fcmd.snk   = sink_q;

	mecf_flow #(
		.NODES (NODES)
	) u_flow (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (fcmd),
		.ld_we   (state_q == T_LOAD),
		.ld_addr (r_q),
		.ld_row  (ld_row),
		.stat    (fstat)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			source_q     <= SOURCE_RST;
			sink_q       <= SINK_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_NODE_COUNT: node_count_q <= cfg_data;
				REG_SOURCE:     source_q     <= cfg_data[NODE_W-1:0];
				REG_SINK:       sink_q       <= cfg_data[NODE_W-1:0];
				default: ;
			endcase
		end
	end

	// adjacency matrix, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NODES; j++) adj_q[j] <= '0;
		end else if (in_acc && (op == OP_WRITE) &&
		             (32'(row_node) < 32'(NODES)) && (32'(col_node) < 32'(NODES))) begin
			adj_q[row_node[IW-1:0]][col_node[IW-1:0]] <= edge_present;
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE: begin
				if (run_acc) begin
					if (source_q == sink_q) state_d = T_EMIT;
					else if (neff == '0)    state_d = T_FSTART;
					else                    state_d = T_LOAD;
				end
			end
			T_LOAD:   if ((CNT_W'(r_q) + CNT_W'(1)) == n_q) state_d = T_FSTART;
			T_FSTART: state_d = T_FWAIT;
			T_FWAIT:  if (fstat.done) state_d = T_SCAN;
			T_SCAN: begin
				if ((flow_q == '0) || (k_q >= n_q)) state_d = T_EMIT;
				else if (cur_edge)                  state_d = T_LOAD;
			end
			T_EMIT:   state_d = T_OUT;
			T_OUT: begin
				if (out_acc) state_d = last ? T_IDLE : T_EMIT;
			end
			default:  state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= T_IDLE;
		else         state_q <= state_d;
	end

	// run registers, edge lists and the result word
	always_ff @(posedge clk) begin
		unique case (state_q)
			T_IDLE: begin
				if (run_acc) begin
					err_q   <= (source_q == sink_q);
					n_q     <= neff;
					k_q     <= '0;
					l_q     <= '0;
					r_q     <= '0;
					count_q <= '0;
					idx_q   <= '0;
					base_q  <= 1'b1;
					for (int j = 0; j < NODES; j++) red_q[j] <= adj_q[j];
				end
			end
			T_LOAD: r_q <= r_q + IW'(1);
			T_FWAIT: begin
				if (fstat.done) begin
					if (base_q) begin
						flow_q <= fstat.total;
						base_q <= 1'b0;
					end else begin
						if (trial_cut) begin
							from_q[count_q[IW-1:0]]   <= k_q[IW-1:0];
							to_q[count_q[IW-1:0]]     <= l_q;
							red_q[k_q[IW-1:0]][l_q]   <= 1'b0;
							flow_q                    <= flow_q - CNT_W'(1);
							count_q                   <= count_q + CNT_W'(1);
						end
						if (l_end) begin
							l_q <= '0;
							k_q <= k_q + CNT_W'(1);
						end else begin
							l_q <= l_q + IW'(1);
						end
					end
				end
			end
			T_SCAN: begin
				r_q <= '0;
				if (!((flow_q == '0) || (k_q >= n_q)) && !cur_edge) begin
					if (l_end) begin
						l_q <= '0;
						k_q <= k_q + CNT_W'(1);
					end else begin
						l_q <= l_q + IW'(1);
					end
				end
			end
			T_EMIT: begin
				if (err_q) begin
					status     <= ST_SAME_END;
					edge_valid <= 1'b0;
					cut_from   <= '0;
					cut_to     <= '0;
					cut_size   <= '0;
					last       <= 1'b1;
				end else if (count_q == '0) begin
					status     <= ST_OK;
					edge_valid <= 1'b0;
					cut_from   <= '0;
					cut_to     <= '0;
					cut_size   <= '0;
					last       <= 1'b1;
				end else begin
					status     <= ST_OK;
					edge_valid <= 1'b1;
					cut_from   <= NODE_W'(from_q[idx_q[IW-1:0]]);
					cut_to     <= NODE_W'(to_q[idx_q[IW-1:0]]);
					cut_size   <= count_q[NODE_W-1:0];
					last       <= ((idx_q + CNT_W'(1)) == count_q);
				end
			end
			T_OUT: if (out_acc) idx_q <= idx_q + CNT_W'(1);
			T_FSTART: ;
			default: ;
		endcase
	end

	// no input word is taken while a result word is pending
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input taken while a result word is pending");

	// a taken word that is not the last is followed by another result word
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> (state_q == T_EMIT))
		else $error("run ended before its last word");

	// residual rows are only loaded while the flow engine is idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_LOAD) |-> !fstat.busy)
		else $error("residual load during a flow search");

	// a flow start always finds the engine idle
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fcmd.start |-> !fstat.busy)
		else $error("flow start while engine busy");

endmodule

[verif/min_edge_cut_by_max_flow_tb.sv]
// testbench for the minimum edge cut block: directed and random runs checked against a predictor
`timescale 1ns / 1ps

module min_edge_cut_by_max_flow_tb;
	import mecf_pkg::*;

	localparam int  NODES       = 32;
	localparam int  CYCLE_LIMIT = 4000000;
	localparam int  SETTLE      = 16;

	typedef struct packed {
		logic              status;
		logic              edge_valid;
		logic [NODE_W-1:0] cut_from;
		logic [NODE_W-1:0] cut_to;
		logic [NODE_W-1:0] cut_size;
		logic              last;
	} cut_word_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CADDR_W-1:0]  cfg_addr;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic                op;
	logic [NODE_W-1:0]   row_node;
	logic [NODE_W-1:0]   col_node;
	logic                edge_present;
	logic                out_valid;
	logic                out_ready;
	logic                status;
	logic                edge_valid;
	logic [NODE_W-1:0]   cut_from;
	logic [NODE_W-1:0]   cut_to;
	logic [NODE_W-1:0]   cut_size;
	logic                last;

	// predictor state
	bit        adj_bits [NODES][NODES];
	bit        kept_bits [NODES][NODES];
	int        res_cap [NODES][NODES];
	int        width_lab [NODES];
	bit        seen [NODES];
	int        parent [NODES];
	int        cfg_nodes;
	int        cfg_src;
	int        cfg_snk;

	cut_word_t expected_cut[$];
	int        mismatches;
	int        cycles;
	int        send_idle_pct;
	int        recv_idle_pct;

	min_edge_cut_by_max_flow i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .row_node(row_node), .col_node(col_node), .edge_present(edge_present),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .edge_valid(edge_valid), .cut_from(cut_from),
		.cut_to(cut_to), .cut_size(cut_size), .last(last)
	);

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// residual capacities from the working edge copy
	function automatic void load_caps(int n);
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				res_cap[i][j] = kept_bits[i][j] ? 1 : 0;
	endfunction

	// unit capacity max flow by widest augmenting paths
	function automatic int widest_flow(int n, int s, int t);
		int total;
		int pick;
		bit found;
		int amt;
		int cur;
		int par;
		int guard;
		total = 0;
		if (s >= n || t >= n)
			return 0;
		forever begin
			pick = 0;
			for (int i = 0; i < n; i++) begin
				seen[i] = 1'b0;
				width_lab[i] = 0;
			end
			width_lab[s] = 1000000000;
			forever begin
				found = 1'b0;
				for (int i = 0; i < n; i++)
					if (!seen[i] && width_lab[i] != 0 &&
					    (!found || width_lab[i] > width_lab[pick])) begin
						pick = i;
						found = 1'b1;
					end
				if (!found)
					return total;
				if (pick == t)
					break;
				seen[pick] = 1'b1;
				for (int i = 0; i < n; i++)
					if (res_cap[pick][i] > width_lab[i] && width_lab[pick] > width_lab[i]) begin
						width_lab[i] = (res_cap[pick][i] < width_lab[pick]) ?
							res_cap[pick][i] : width_lab[pick];
						parent[i] = pick;
					end
			end
			amt = width_lab[t];
			cur = t;
			guard = 0;
			total += amt;
			while (cur != s && guard < n) begin
				par = parent[cur] % NODES;
				res_cap[par][cur] = (res_cap[par][cur] - amt) & 8'hff;
				res_cap[cur][par] = (res_cap[cur][par] + amt) & 8'hff;
				cur = par;
				guard++;
			end
		end
	endfunction

	// expected words of one run
	function automatic void predict_cut();
		int n;
		int flow;
		int count;
		int from_q[$];
		int to_q[$];
		cut_word_t w;
		if (cfg_src == cfg_snk) begin
			w = '{ST_SAME_END, 1'b0, '0, '0, '0, 1'b1};
			expected_cut.push_back(w);
			return;
		end
		n = (cfg_nodes > NODES) ? NODES : cfg_nodes;
		for (int k = 0; k < n; k++)
			for (int l = 0; l < n; l++)
				kept_bits[k][l] = adj_bits[k][l];
		load_caps(n);
		flow = widest_flow(n, cfg_src, cfg_snk);
		count = 0;
		for (int k = 0; k < n && flow != 0; k++)
			for (int l = 0; l < n && flow != 0; l++) begin
				if (!kept_bits[k][l])
					continue;
				load_caps(n);
				res_cap[k][l] = 0;
				if (widest_flow(n, cfg_src, cfg_snk) < flow) begin
					from_q.push_back(k);
					to_q.push_back(l);
					count++;
					kept_bits[k][l] = 1'b0;
					flow--;
				end
			end
		if (count == 0) begin
			w = '{ST_OK, 1'b0, '0, '0, '0, 1'b1};
			expected_cut.push_back(w);
			return;
		end
		for (int k = 0; k < count; k++) begin
			w.status     = ST_OK;
			w.edge_valid = 1'b1;
			w.cut_from   = NODE_W'(from_q[k]);
			w.cut_to     = NODE_W'(to_q[k]);
			w.cut_size   = NODE_W'(count);
			w.last       = (k + 1 == count);
			expected_cut.push_back(w);
		end
	endfunction

	// send one input word and update the prediction on acceptance
	task automatic send_word(logic o, int r, int c, logic e);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		op           <= o;
		row_node     <= NODE_W'(r);
		col_node     <= NODE_W'(c);
		edge_present <= e;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (o == OP_WRITE)
			adj_bits[r][c] = e;
		else
			predict_cut();
	endtask

	// wait for every expected word, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_cut.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CADDR_W-1:0] idx, int value);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= CFG_W'(value);
		@(posedge clk);
		case (idx)
			REG_NODE_COUNT: cfg_nodes = value & 63;
			REG_SOURCE:     cfg_src = value & 31;
			REG_SINK:       cfg_snk = value & 31;
			default: ;
		endcase
	endtask

	task automatic set_graph(int n, int s, int t);
		drain();
		write_reg(REG_NODE_COUNT, n);
		write_reg(REG_SOURCE, s);
		write_reg(REG_SINK, t);
		cfg_we <= 1'b0;
	endtask

	// extremes, special cases and a small hand-built graph
	task automatic test_directed();
		send_word(OP_RUN, 0, 0, 1'b0);
		send_word(OP_WRITE, 0, 31, 1'b1);
		send_word(OP_WRITE, 31, 31, 1'b1);
		send_word(OP_WRITE, 31, 31, 1'b0);
		send_word(OP_RUN, 0, 0, 1'b0);
		set_graph(4, 0, 3);
		send_word(OP_WRITE, 0, 1, 1'b1);
		send_word(OP_WRITE, 0, 2, 1'b1);
		send_word(OP_WRITE, 1, 3, 1'b1);
		send_word(OP_WRITE, 2, 3, 1'b1);
		send_word(OP_WRITE, 1, 2, 1'b1);
		send_word(OP_WRITE, 3, 0, 1'b1);
		send_word(OP_WRITE, 3, 0, 1'b0);
		send_word(OP_RUN, 31, 31, 1'b1);
		// source equal to sink
		set_graph(4, 2, 2);
		send_word(OP_RUN, 0, 0, 1'b0);
		// source beyond the node count
		set_graph(4, 5, 3);
		send_word(OP_RUN, 0, 0, 1'b0);
		// no nodes at all
		set_graph(0, 0, 3);
		send_word(OP_RUN, 0, 0, 1'b0);
		// one node only
		set_graph(1, 0, 1);
		send_word(OP_RUN, 0, 0, 1'b0);
		// node count saturated, sink at the top node
		set_graph(63, 0, 31);
		send_word(OP_RUN, 0, 0, 1'b0);
		set_graph(33, 3, 31);
		send_word(OP_RUN, 0, 0, 1'b0);
	endtask

	// random graphs on a few nodes, reconfigured every few dozen words
	task automatic test_random(int s_pct, int r_pct, int words);
		int n;
		int s;
		int t;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < words; i++) begin
			if (i % 35 == 0) begin
				n = $urandom_range(6, 2);
				s = $urandom_range(n - 1);
				t = $urandom_range(n - 1);
				if ($urandom_range(9) == 0)
					t = s;
				else if ($urandom_range(9) == 0)
					t = n;
				set_graph(n, s, t);
			end
			if ($urandom_range(99) < 14)
				send_word(OP_RUN, $urandom_range(31), $urandom_range(31),
					1'($urandom_range(1)));
			else if ($urandom_range(19) == 0)
				// wide writes reach high node bits, beyond the nodes in use
				send_word(OP_WRITE, $urandom_range(31, 8), $urandom_range(31, 8),
					1'($urandom_range(1)));
			else
				send_word(OP_WRITE, $urandom_range(n - 1), $urandom_range(n - 1),
					1'($urandom_range(1)));
		end
		drain();
	endtask

	// result checker and receiver stall
	always @(posedge clk) begin
		cut_word_t want;
		cut_word_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{status, edge_valid, cut_from, cut_to, cut_size, last};
			if (expected_cut.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %p", got);
			end else begin
				want = expected_cut.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word mismatch: expected %p, actual %p", want, got);
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// run time limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("min_edge_cut_by_max_flow_tb: done, errors");
			$finish;
		end
	end

	initial begin
		mismatches    = 0;
		cycles        = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		cfg_nodes     = NODE_COUNT_RST;
		cfg_src       = SOURCE_RST;
		cfg_snk       = SINK_RST;
		for (int i = 0; i < NODES; i++) begin
			parent[i] = 0;
			for (int j = 0; j < NODES; j++)
				adj_bits[i][j] = 1'b0;
		end
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_addr     = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		op           = OP_WRITE;
		row_node     = '0;
		col_node     = '0;
		edge_present = 1'b0;
		out_ready    = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(17, 59, 140);
		test_random(59, 17, 140);
		test_random(0, 0, 140);
		drain();
		if (mismatches == 0 && expected_cut.size() == 0)
			$display("min_edge_cut_by_max_flow_tb: done, clean");
		else
			$display("min_edge_cut_by_max_flow_tb: done, errors");
		$finish;
	end

endmodule
